FILE: rtl/core/yuvrgb_pkg.sv
// Types and constants shared by the 4:2:0 block to RGB converter.
package yuvrgb_pkg;

    localparam logic [7:0] LUMA_LOW    = 8'd16;
    localparam logic [7:0] LUMA_HIGH   = 8'd240;
    localparam logic [7:0] CHROMA_HIGH = 8'd240;
    localparam logic [7:0] CHROMA_MID  = 8'd128;

    localparam logic        [16:0] COEF_Y  = 17'd298;
    localparam logic signed [17:0] COEF_RV = 18'sd408;
    localparam logic signed [17:0] COEF_GV = -18'sd208;
    localparam logic signed [17:0] COEF_GU = -18'sd100;
    localparam logic signed [17:0] COEF_BU = 18'sd517;

    typedef struct packed {
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
    } block_in_t;

    typedef struct packed {
        logic [7:0] red_tl;
        logic [7:0] green_tl;
        logic [7:0] blue_tl;
        logic [7:0] red_tr;
        logic [7:0] green_tr;
        logic [7:0] blue_tr;
        logic [7:0] red_bl;
        logic [7:0] green_bl;
        logic [7:0] blue_bl;
        logic [7:0] red_br;
        logic [7:0] green_br;
        logic [7:0] blue_br;
    } pixels_out_t;

endpackage

FILE: rtl/core/yuv420_block_to_rgb.sv
// 2x2 block YUV 4:2:0 to RGB converter, three-stage pipeline.
// Stages in order: clamp, multiply, add/saturate, each ending in a register.
// Throughput: one block per cycle without rgb_stall; each stage register advances when
// it is empty or the stage after it moves; a result-side stall backs up all three stages.
// Reset clears the stage valid bits only; no result is pending after reset.
// No configuration and no state other than the pipeline itself.
module yuv420_block_to_rgb (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    blk_valid,
    output logic                    blk_stall,
    input  yuvrgb_pkg::block_in_t   blk,
    output logic                    rgb_valid,
    input  logic                    rgb_stall,
    output yuvrgb_pkg::pixels_out_t rgb
);
    import yuvrgb_pkg::*;

    // stage 1: clamped luma offsets and centered chroma
    logic              s1_valid_reg;
    logic [7:0]        s1_y_reg [4];
    logic [7:0]        s1_y_next [4];
    logic signed [8:0] s1_u_reg, s1_u_next;
    logic signed [8:0] s1_v_reg, s1_v_next;

    // stage 2: products
    logic               s2_valid_reg;
    logic [16:0]        s2_y_reg [4];
    logic [16:0]        s2_y_next [4];
    logic signed [17:0] s2_rv_reg, s2_rv_next;
    logic signed [17:0] s2_gv_reg, s2_gv_next;
    logic signed [17:0] s2_gu_reg, s2_gu_next;
    logic signed [17:0] s2_bu_reg, s2_bu_next;

    // stage 3: saturated channels
    logic        rgb_valid_reg;
    pixels_out_t rgb_reg, rgb_next;

    logic s1_ready, s2_ready, s3_ready;

    assign s3_ready  = !rgb_valid_reg || !rgb_stall;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign blk_stall = !s1_ready;

    function automatic logic [7:0] luma_offset(input logic [7:0] y);
        logic [7:0] c;
        begin
            c = y;
            if (c < LUMA_LOW)
            begin
                c = LUMA_LOW;
            end
            if (c > LUMA_HIGH)
            begin
                c = LUMA_HIGH;
            end
            luma_offset = c - LUMA_LOW;
        end
    endfunction

    function automatic logic signed [8:0] chroma_center(input logic [7:0] c);
        logic [7:0] k;
        begin
            k = (c > CHROMA_HIGH) ? CHROMA_HIGH : c;
            chroma_center = $signed({1'b0, k}) - $signed({1'b0, CHROMA_MID});
        end
    endfunction

    function automatic logic [7:0] saturate(input logic signed [18:0] s);
        begin
            if (s[18])
            begin
                saturate = 8'd0;
            end
            else if (s[17:16] != 2'b00)
            begin
                saturate = 8'd255;
            end
            else
            begin
                saturate = s[15:8];
            end
        end
    endfunction

    always_comb
    begin
        s1_y_next[0] = luma_offset(blk.luma_top_left);
        s1_y_next[1] = luma_offset(blk.luma_top_right);
        s1_y_next[2] = luma_offset(blk.luma_bottom_left);
        s1_y_next[3] = luma_offset(blk.luma_bottom_right);
        s1_u_next    = chroma_center(blk.chroma_u);
        s1_v_next    = chroma_center(blk.chroma_v);
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            s2_y_next[i] = {9'd0, s1_y_reg[i]} * COEF_Y;
        end
        s2_rv_next = 18'(s1_v_reg * COEF_RV);
        s2_gv_next = 18'(s1_v_reg * COEF_GV);
        s2_gu_next = 18'(s1_u_reg * COEF_GU);
        s2_bu_next = 18'(s1_u_reg * COEF_BU);
    end

    logic signed [18:0] sum_r [4];
    logic signed [18:0] sum_g [4];
    logic signed [18:0] sum_b [4];
    logic signed [18:0] g_term;

    always_comb
    begin
        g_term = 19'(s2_gv_reg) + 19'(s2_gu_reg);
        for (int i = 0; i < 4; i++)
        begin
            sum_r[i] = $signed({2'b00, s2_y_reg[i]}) + 19'(s2_rv_reg);
            sum_g[i] = $signed({2'b00, s2_y_reg[i]}) + g_term;
            sum_b[i] = $signed({2'b00, s2_y_reg[i]}) + 19'(s2_bu_reg);
        end
        rgb_next.red_tl   = saturate(sum_r[0]);
        rgb_next.green_tl = saturate(sum_g[0]);
        rgb_next.blue_tl  = saturate(sum_b[0]);
        rgb_next.red_tr   = saturate(sum_r[1]);
        rgb_next.green_tr = saturate(sum_g[1]);
        rgb_next.blue_tr  = saturate(sum_b[1]);
        rgb_next.red_bl   = saturate(sum_r[2]);
        rgb_next.green_bl = saturate(sum_g[2]);
        rgb_next.blue_bl  = saturate(sum_b[2]);
        rgb_next.red_br   = saturate(sum_r[3]);
        rgb_next.green_br = saturate(sum_g[3]);
        rgb_next.blue_br  = saturate(sum_b[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rgb_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= blk_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                rgb_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && blk_valid)
        begin
            s1_y_reg <= s1_y_next;
            s1_u_reg <= s1_u_next;
            s1_v_reg <= s1_v_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_y_reg  <= s2_y_next;
            s2_rv_reg <= s2_rv_next;
            s2_gv_reg <= s2_gv_next;
            s2_gu_reg <= s2_gu_next;
            s2_bu_reg <= s2_bu_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb_valid = rgb_valid_reg;
    assign rgb       = rgb_reg;

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid && !blk_stall |=> s1_valid_reg)
        else $error("accepted block did not reach stage 1");

    a_s2_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s3_ready |=> rgb_valid_reg)
        else $error("stage 2 item lost on the way to the output");

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg)
        else $error("stalled stage 1 item dropped");

    a_free_output_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rgb_stall |-> !blk_stall)
        else $error("input stalled while the output is free");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        blk_stall |-> s1_valid_reg && s2_valid_reg && rgb_valid_reg && rgb_stall)
        else $error("input stalled with a bubble in the pipeline");

endmodule
